>>> rtl/pspk_pkg.sv
// Package for the program stream PES packer.
// Holds widths, register indexes, stream constants, the phase enum and the plan struct.
// No dependencies.
package pspk_pkg;

  localparam int unsigned PSPK_PACK_BYTES = 2048;
  localparam int unsigned PSPK_MAX_UNIT   = 131072;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned LEN_W      = 18;
  localparam int unsigned PTS_W      = 33;
  localparam int unsigned ROOM_W     = 12;
  localparam int unsigned MUX_W      = 22;
  localparam int unsigned LEAD_W     = 17;
  localparam int unsigned PES_LEN_W  = 16;
  localparam int unsigned HLEN_W     = 4;
  localparam int unsigned STUFF_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_MUX_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCR_LEAD = 2'd1;

  localparam logic [MUX_W-1:0]  MUX_RATE_RST = 22'd1500;
  localparam logic [LEAD_W-1:0] SCR_LEAD_RST = 17'd900;

  localparam logic [7:0] SID_PACK  = 8'hBA;
  localparam logic [7:0] SID_VIDEO = 8'hE0;
  localparam logic [7:0] SID_PAD   = 8'hBE;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  localparam int unsigned HDR_PACK      = 14;
  localparam int unsigned HDR_PES       = 9;
  localparam int unsigned HDR_PTS       = 5;
  localparam int unsigned PES_OPT_BYTES = 3;
  localparam int unsigned MIN_PAYLOAD   = 16;
  localparam int unsigned PAD_HDR       = 6;

  // Segments of the result sequence for one input, in emission order.
  typedef enum logic [3:0] {
    PH_RUN1,
    PH_C1HDR,
    PH_C1RUN,
    PH_PACK,
    PH_PES,
    PH_PTS,
    PH_STUFF,
    PH_DATA,
    PH_RUN2,
    PH_C2HDR,
    PH_C2RUN
  } phase_e;

  localparam int unsigned NUM_PHASES = 11;

  typedef struct packed {
    logic [NUM_PHASES-1:0] mask;
    logic [ROOM_W-1:0]     run1_n;
    logic [ROOM_W-1:0]     c1_n;
    logic [PTS_W-1:0]      scr;
    logic [PES_LEN_W-1:0]  pes_len;
    logic                  pes_first;
    logic [HLEN_W-1:0]     pes_hlen;
    logic [PTS_W-1:0]      pts;
    logic [STUFF_W-1:0]    stuff;
    logic [DATA_W-1:0]     data;
    logic [ROOM_W-1:0]     run2_n;
    logic [ROOM_W-1:0]     c2_n;
  } plan_t;

endpackage

>>> rtl/pspk_ifs.sv
// Stream and configuration channel interfaces of the program stream PES packer.
// Depends on pspk_pkg for field widths.
interface pspk_in_if import pspk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              unit_start;
  logic [LEN_W-1:0]  unit_length;
  logic [PTS_W-1:0]  pts;
  logic              stream_end;

  modport source (output valid, data_byte, unit_start, unit_length, pts, stream_end,
                  input ready);
  modport sink (input valid, data_byte, unit_start, unit_length, pts, stream_end,
                output ready);
endinterface

interface pspk_out_if import pspk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_byte;
  logic              fill_run;
  logic [ROOM_W-1:0] run_length;
  logic              last;

  modport source (output valid, out_byte, fill_run, run_length, last, input ready);
  modport sink (input valid, out_byte, fill_run, run_length, last, output ready);
endinterface

interface pspk_cfg_if import pspk_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink (input valid, idx, wdata, output ready);
endinterface

>>> rtl/pspk_cfg.sv
// Configuration registers of the program stream PES packer: mux rate and SCR lead.
// Depends on pspk_pkg and pspk_cfg_if.
module pspk_cfg import pspk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  pspk_cfg_if.sink          cfg_i,
  output logic [MUX_W-1:0]  mux_rate_o,
  output logic [LEAD_W-1:0] scr_lead_o
);

  logic [MUX_W-1:0]  mux_rate_q;
  logic [LEAD_W-1:0] scr_lead_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mux_rate_q <= MUX_RATE_RST;
      scr_lead_q <= SCR_LEAD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        CFG_MUX_RATE: mux_rate_q <= cfg_i.wdata[MUX_W-1:0];
        CFG_SCR_LEAD: scr_lead_q <= cfg_i.wdata[LEAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign mux_rate_o = mux_rate_q;
  assign scr_lead_o = scr_lead_q;

endmodule

>>> rtl/pspk_planner.sv
// Input side of the program stream PES packer: pack and PES bookkeeping state.
// Turns each accepted input transaction into a plan of result segments.
// Depends on pspk_pkg and pspk_in_if.
module pspk_planner import pspk_pkg::*; #(
  parameter int unsigned PACK_BYTES = PSPK_PACK_BYTES,
  parameter int unsigned MAX_UNIT   = PSPK_MAX_UNIT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pspk_in_if.sink           in_i,
  input  logic [LEAD_W-1:0] scr_lead_i,
  input  logic              plan_ready_i,
  output logic              plan_we_o,
  output plan_t             plan_o
);

  localparam logic [ROOM_W-1:0] RoomOpen   = ROOM_W'(PACK_BYTES - HDR_PACK);
  localparam logic [ROOM_W-1:0] SpaceNewP  = ROOM_W'(PACK_BYTES - HDR_PACK - HDR_PES - HDR_PTS);
  localparam logic [ROOM_W-1:0] SpaceNew   = ROOM_W'(PACK_BYTES - HDR_PACK - HDR_PES);
  localparam logic [ROOM_W-1:0] FitP       = ROOM_W'(HDR_PES + HDR_PTS + MIN_PAYLOAD);
  localparam logic [ROOM_W-1:0] Fit        = ROOM_W'(HDR_PES + MIN_PAYLOAD);
  localparam logic [ROOM_W-1:0] HdrPesP    = ROOM_W'(HDR_PES + HDR_PTS);
  localparam logic [ROOM_W-1:0] HdrPes     = ROOM_W'(HDR_PES);
  localparam logic [ROOM_W-1:0] PadHdr     = ROOM_W'(PAD_HDR);
  localparam logic [LEN_W:0]    MaxUnit    = (LEN_W+1)'(MAX_UNIT);

  logic              pa_q, pa_d;
  logic [ROOM_W-1:0] room_q, room_d;
  logic [PTS_W-1:0]  scr_q, scr_d;
  logic [LEN_W-1:0]  ur_q, ur_d;
  logic [ROOM_W-1:0] pr_q, pr_d;
  logic              fp_q, fp_d;

  logic              accept;
  logic [LEN_W-1:0]  ul, ul_c, ur0;
  logic [ROOM_W-1:0] pr0, pr1, room1, space, take, spare, c1_n, c2_n;
  logic [PTS_W:0]    scr_diff;
  logic [PTS_W-1:0]  scr0;
  logic [STUFF_W-1:0] stuff;
  logic [HLEN_W-1:0] extra;
  logic              fp0, start, data_en, need_new, room_fit, pa1;

  assign in_i.ready = plan_ready_i;
  assign accept     = in_i.valid & plan_ready_i;
  assign plan_we_o  = accept;

  always_comb begin
    plan_o = '0;

    // New unit: clamp length, form SCR, drop what the open PES packet still owes.
    ul       = (in_i.unit_length == '0) ? LEN_W'(1) : in_i.unit_length;
    ul_c     = ({1'b0, ul} > MaxUnit) ? MaxUnit[LEN_W-1:0] : ul;
    scr_diff = {1'b0, in_i.pts} - (PTS_W+1)'(scr_lead_i);
    scr0     = in_i.unit_start ? (scr_diff[PTS_W] ? '0 : scr_diff[PTS_W-1:0]) : scr_q;
    pr0      = in_i.unit_start ? '0 : pr_q;
    ur0      = in_i.unit_start ? ul_c : ur_q;
    fp0      = in_i.unit_start | fp_q;

    plan_o.mask[PH_RUN1] = in_i.unit_start & (pr_q != '0);
    plan_o.run1_n        = pr_q;

    data_en  = (ur0 != '0);
    start    = data_en & (pr0 == '0);
    room_fit = fp0 ? (room_q >= FitP) : (room_q >= Fit);
    need_new = !pa_q || !room_fit;

    // Close of the old pack ahead of a new one.
    c1_n                  = (room_q >= PadHdr) ? room_q - PadHdr : room_q;
    plan_o.c1_n           = c1_n;
    plan_o.mask[PH_C1HDR] = start & need_new & pa_q & (room_q >= PadHdr);
    plan_o.mask[PH_C1RUN] = start & need_new & pa_q & (c1_n != '0);
    plan_o.mask[PH_PACK]  = start & need_new;
    plan_o.scr            = scr0;

    if (need_new) begin
      space = fp0 ? SpaceNewP : SpaceNew;
    end else begin
      space = fp0 ? room_q - HdrPesP : room_q - HdrPes;
    end
    take  = ({{(LEN_W-ROOM_W){1'b0}}, space} > ur0) ? ur0[ROOM_W-1:0] : space;
    spare = space - take;
    stuff = (spare < PadHdr) ? spare[STUFF_W-1:0] : '0;
    extra = fp0 ? HLEN_W'(HDR_PTS) : '0;

    plan_o.mask[PH_PES]   = start;
    plan_o.mask[PH_PTS]   = start & fp0;
    plan_o.mask[PH_STUFF] = start & (stuff != '0);
    plan_o.pes_len        = PES_LEN_W'(PES_OPT_BYTES) + PES_LEN_W'(extra)
                          + PES_LEN_W'(stuff) + PES_LEN_W'(take);
    plan_o.pes_first      = fp0;
    plan_o.pes_hlen       = extra + HLEN_W'(stuff);
    plan_o.pts            = in_i.pts;
    plan_o.stuff          = stuff;

    room1 = start ? spare - ROOM_W'(stuff) : room_q;
    pa1   = start | pa_q;
    pr1   = start ? take : pr0;

    plan_o.mask[PH_DATA] = data_en;
    plan_o.data          = in_i.data_byte;

    pa_d   = pa1;
    room_d = room1;
    scr_d  = scr0;
    pr_d   = data_en ? pr1 - ROOM_W'(1) : pr1;
    ur_d   = data_en ? ur0 - LEN_W'(1) : ur0;
    fp_d   = start ? 1'b0 : fp0;

    // Stream end: flush owed payload, then close the pack.
    c2_n          = (room1 >= PadHdr) ? room1 - PadHdr : room1;
    plan_o.run2_n = pr_d;
    plan_o.c2_n   = c2_n;
    if (in_i.stream_end) begin
      plan_o.mask[PH_RUN2]  = (pr_d != '0);
      plan_o.mask[PH_C2HDR] = pa1 & (room1 >= PadHdr);
      plan_o.mask[PH_C2RUN] = pa1 & (c2_n != '0);
      pa_d   = 1'b0;
      room_d = '0;
      pr_d   = '0;
      ur_d   = '0;
      fp_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q   <= 1'b0;
      room_q <= '0;
      scr_q  <= '0;
      ur_q   <= '0;
      pr_q   <= '0;
      fp_q   <= 1'b0;
    end else if (accept) begin
      pa_q   <= pa_d;
      room_q <= room_d;
      scr_q  <= scr_d;
      ur_q   <= ur_d;
      pr_q   <= pr_d;
      fp_q   <= fp_d;
    end
  end

endmodule

>>> rtl/pspk_emitter.sv
// Output side of the program stream PES packer: walks a plan one result item per
// cycle unless stalled into the output register; needs pspk_pkg and pspk_out_if.
module pspk_emitter import pspk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             plan_we_i,
  input  plan_t            plan_i,
  input  logic [MUX_W-1:0] mux_rate_i,
  output logic             plan_ready_o,
  pspk_out_if.source       out_o
);

  function automatic logic [7:0] start_code(input logic [3:0] pos, input logic [7:0] sid);
    logic [7:0] b;
    case (pos)
      4'd0, 4'd1: b = 8'h00;
      4'd2:       b = 8'h01;
      default:    b = sid;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pad_byte(input logic [3:0] pos, input logic [ROOM_W-1:0] n);
    logic [7:0] b;
    case (pos)
      4'd4:    b = 8'(n[ROOM_W-1:8]);
      4'd5:    b = n[7:0];
      default: b = start_code(pos, SID_PAD);
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pack_byte(input logic [3:0] pos, input logic [PTS_W-1:0] s,
                                           input logic [MUX_W-1:0] r);
    logic [7:0] b;
    case (pos)
      4'd4:    b = {2'b01, s[32:30], 1'b1, s[29:28]};
      4'd5:    b = s[27:20];
      4'd6:    b = {s[19:15], 1'b1, s[14:13]};
      4'd7:    b = s[12:5];
      4'd8:    b = {s[4:0], 3'b100};
      4'd9:    b = 8'h01;
      4'd10:   b = r[21:14];
      4'd11:   b = r[13:6];
      4'd12:   b = {r[5:0], 2'b11};
      4'd13:   b = 8'hF8;
      default: b = start_code(pos, SID_PACK);
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pes_byte(input logic [3:0] pos, input plan_t p);
    logic [7:0] b;
    case (pos)
      4'd4:    b = p.pes_len[15:8];
      4'd5:    b = p.pes_len[7:0];
      4'd6:    b = 8'h80;
      4'd7:    b = p.pes_first ? 8'h80 : 8'h00;
      4'd8:    b = 8'(p.pes_hlen);
      default: b = start_code(pos, SID_VIDEO);
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pts_byte(input logic [3:0] pos, input logic [PTS_W-1:0] t);
    logic [7:0] b;
    case (pos)
      4'd0:    b = {4'b0010, t[32:30], 1'b1};
      4'd1:    b = t[29:22];
      4'd2:    b = {t[21:15], 1'b1};
      4'd3:    b = t[14:7];
      default: b = {t[6:0], 1'b1};
    endcase
    return b;
  endfunction

  plan_t                 plan_q;
  logic [NUM_PHASES-1:0] mask_q, mask_rest, cur_bit;
  logic [3:0]            idx_q, len_m1, cur;
  phase_e                cur_phase;
  logic                  busy, adv, emit, phase_done, item_last;

  logic                  out_valid_q;
  logic [DATA_W-1:0]     out_byte_q, item_byte;
  logic                  fill_q, item_fill;
  logic [ROOM_W-1:0]     run_q, item_run;
  logic                  last_q;

  // Current segment is the lowest pending bit of the mask.
  always_comb begin
    cur = '0;
    for (int i = NUM_PHASES - 1; i >= 0; i--) begin
      if (mask_q[i]) cur = 4'(i);
    end
  end

  assign cur_phase = phase_e'(cur);
  assign cur_bit   = {{(NUM_PHASES-1){1'b0}}, 1'b1} << cur;
  assign mask_rest = mask_q & ~cur_bit;

  always_comb begin
    item_byte = FILL_BYTE;
    item_fill = 1'b0;
    item_run  = '0;
    len_m1    = '0;
    case (cur_phase)
      PH_RUN1: begin
        item_fill = 1'b1;
        item_run  = plan_q.run1_n;
      end
      PH_C1HDR: begin
        item_byte = pad_byte(idx_q, plan_q.c1_n);
        len_m1    = 4'(PAD_HDR - 1);
      end
      PH_C1RUN: begin
        item_fill = 1'b1;
        item_run  = plan_q.c1_n;
      end
      PH_PACK: begin
        item_byte = pack_byte(idx_q, plan_q.scr, mux_rate_i);
        len_m1    = 4'(HDR_PACK - 1);
      end
      PH_PES: begin
        item_byte = pes_byte(idx_q, plan_q);
        len_m1    = 4'(HDR_PES - 1);
      end
      PH_PTS: begin
        item_byte = pts_byte(idx_q, plan_q.pts);
        len_m1    = 4'(HDR_PTS - 1);
      end
      PH_STUFF: begin
        len_m1 = 4'(plan_q.stuff) - 4'd1;
      end
      PH_DATA: begin
        item_byte = plan_q.data;
      end
      PH_RUN2: begin
        item_fill = 1'b1;
        item_run  = plan_q.run2_n;
      end
      PH_C2HDR: begin
        item_byte = pad_byte(idx_q, plan_q.c2_n);
        len_m1    = 4'(PAD_HDR - 1);
      end
      PH_C2RUN: begin
        item_fill = 1'b1;
        item_run  = plan_q.c2_n;
      end
      default: ;
    endcase
  end

  assign busy         = (mask_q != '0);
  assign adv          = !out_valid_q || out_o.ready;
  assign emit         = busy && adv;
  assign phase_done   = (idx_q == len_m1);
  assign item_last    = phase_done && (mask_rest == '0);
  assign plan_ready_o = !busy || (emit && item_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      idx_q  <= '0;
    end else if (plan_we_i) begin
      mask_q <= plan_i.mask;
      idx_q  <= '0;
    end else if (emit) begin
      if (phase_done) begin
        mask_q <= mask_rest;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (plan_we_i) plan_q <= plan_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= item_byte;
      fill_q     <= item_fill;
      run_q      <= item_run;
      last_q     <= item_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.fill_run   = fill_q;
  assign out_o.run_length = run_q;
  assign out_o.last       = last_q;

endmodule

>>> rtl/program_stream_pes_packer.sv
// Top level of the program stream PES packer: configuration, planner and emitter.
// Depends on pspk_pkg, the channel interfaces, pspk_cfg, pspk_planner and pspk_emitter.
//
// Packs access-unit payload bytes into an MPEG-2 program stream of PACK_BYTES-byte
// packs (pack header, video PES packets with PTS on the first packet of each unit,
// padding packet at the end of a pack). Every input transaction is turned into a
// plan at acceptance and its result items leave through a registered output, one
// item per cycle while the output is not stalled; the emitter sets the rate. A
// payload byte that continues an open PES packet is a single result item, so such
// bytes stream at one per cycle when the output does not stall. A byte that opens a
// PES packet, starts a pack or closes one holds the input until all its result items
// (up to 45) have left; padding fill and owed payload leave as single run items.
// Configuration writes take effect at once and must be made while the block is idle.
module program_stream_pes_packer import pspk_pkg::*; #(
  parameter int unsigned PACK_BYTES = PSPK_PACK_BYTES,
  parameter int unsigned MAX_UNIT   = PSPK_MAX_UNIT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pspk_in_if.sink    in_i,
  pspk_out_if.source out_o,
  pspk_cfg_if.sink   cfg_i
);

  logic [MUX_W-1:0]  mux_rate;
  logic [LEAD_W-1:0] scr_lead;
  logic              plan_ready;
  logic              plan_we;
  plan_t             plan;

  pspk_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .mux_rate_o (mux_rate),
    .scr_lead_o (scr_lead)
  );

  pspk_planner #(
    .PACK_BYTES (PACK_BYTES),
    .MAX_UNIT   (MAX_UNIT)
  ) u_planner (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .scr_lead_i   (scr_lead),
    .plan_ready_i (plan_ready),
    .plan_we_o    (plan_we),
    .plan_o       (plan)
  );

  pspk_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_we_i    (plan_we),
    .plan_i       (plan),
    .mux_rate_i   (mux_rate),
    .plan_ready_o (plan_ready),
    .out_o        (out_o)
  );

endmodule
